// File: src/stac_pkg.sv
// types, codes and constants shared by the sorted term accumulator
`timescale 1ns / 1ps
package stac_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // progress of a word through the cell chain
  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_SHIFT = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic signed [31:0] COEFF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COEFF_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] coeff;
    logic signed [15:0] power;
    logic [3:0]         index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] term_coeff;
    logic signed [15:0] term_power;
    logic [4:0]         term_count;
    logic               entry_valid;
    logic               table_full;
    logic               sum_saturated;
  } out_item_t;

  typedef struct packed {
    logic               vld;
    logic               op;
    logic [1:0]         phase;
    logic [3:0]         idx;
    logic signed [15:0] pw;    // searched power, or displaced term while shifting
    logic signed [31:0] cf;
    logic               grew;  // a new term was stored
    out_item_t          res;
  } carry_t;

endpackage

// File: src/stac_cell.sv
// one slot of the sorted term chain: holds a term and passes the carry word on
`timescale 1ns / 1ps
module stac_cell #(
  parameter int MAX_TERMS = stac_pkg::MAX_TERMS_DEF,
  parameter int POS       = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(MAX_TERMS + 1) - 1:0] count,
  input  stac_pkg::carry_t                   cin,
  output stac_pkg::carry_t                   cout
);
  import stac_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);

  logic signed [15:0] pw_r, pw_nxt;
  logic signed [31:0] cf_r, cf_nxt;
  carry_t             carry_r, carry_nxt;
  logic signed [32:0] sum;
  logic               sat;
  logic signed [31:0] sum_clamped;
  logic               occ;
  logic               full;
  logic               idx_hit;

  assign occ     = CW'(POS) < count;
  assign full    = count == CW'(MAX_TERMS);
  assign idx_hit = int'(cin.idx) == POS;

  assign sum         = 33'(cf_r) + 33'(cin.cf);
  assign sat         = sum[32] != sum[31];
  assign sum_clamped = sat ? (sum[32] ? COEFF_MIN : COEFF_MAX) : sum[31:0];

  always_comb begin
    carry_nxt = cin;
    pw_nxt    = pw_r;
    cf_nxt    = cf_r;
    if (cin.vld && cin.phase != PH_DONE) begin
      if (cin.op == OP_READ) begin
        if (idx_hit) begin
          carry_nxt.phase = PH_DONE;
          if (occ) begin
            carry_nxt.res.term_coeff  = cf_r;
            carry_nxt.res.term_power  = pw_r;
            carry_nxt.res.entry_valid = 1'b1;
          end
        end
      end else if (cin.phase == PH_SHIFT) begin
        pw_nxt = cin.pw;
        cf_nxt = cin.cf;
        if (occ) begin
          carry_nxt.pw = pw_r;
          carry_nxt.cf = cf_r;
        end else begin
          carry_nxt.phase = PH_DONE;
        end
      end else if (occ && pw_r == cin.pw) begin
        cf_nxt                      = sum_clamped;
        carry_nxt.phase             = PH_DONE;
        carry_nxt.res.term_coeff    = sum_clamped;
        carry_nxt.res.entry_valid   = 1'b1;
        carry_nxt.res.table_full    = 1'b0;
        carry_nxt.res.sum_saturated = sat;
      end else if (occ && pw_r > cin.pw) begin
        // higher power stays ahead, keep looking
        carry_nxt.phase = PH_SEEK;
      end else if (full) begin
        // no room: the drop result is already in the word
        carry_nxt.phase = PH_DONE;
      end else begin
        pw_nxt                    = cin.pw;
        cf_nxt                    = cin.cf;
        carry_nxt.grew            = 1'b1;
        carry_nxt.res.entry_valid = 1'b1;
        carry_nxt.res.table_full  = 1'b0;
        if (occ) begin
          carry_nxt.phase = PH_SHIFT;
          carry_nxt.pw    = pw_r;
          carry_nxt.cf    = cf_r;
        end else begin
          carry_nxt.phase = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pw_r <= pw_nxt;
    cf_r <= cf_nxt;
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign cout = carry_r;

endmodule

// File: src/sorted_term_accumulator.sv
// top level: sorted polynomial term table built as a chain of term cells
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_stall, in_data    | in
//   result  | out_valid, out_stall, out_data | out
//
// each word walks the chain one cell per cycle; its result is registered in the pending
// register and then in the output register, and the next word is taken once the previous
// result has reached the output register. the chain length sets the spacing of words.
// reset clears the term count and all valid flags; term storage is not cleared.
// a stalled result is held in the output register while the next word runs.
`timescale 1ns / 1ps
module sorted_term_accumulator #(
  parameter int MAX_TERMS = stac_pkg::MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stac_pkg::out_item_t out_data
);
  import stac_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);

  carry_t    chain [MAX_TERMS + 1];
  carry_t    head;
  carry_t    tail;
  logic      busy_r, busy_nxt;
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic [CW - 1:0] count_r, count_nxt;
  logic      accept;
  logic      out_free;
  logic [MAX_TERMS:0] chain_vld;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  always_comb begin
    head       = '0;
    head.vld   = accept;
    head.op    = in_data.op;
    head.phase = PH_SEEK;
    head.idx   = in_data.index;
    head.pw    = in_data.power;
    head.cf    = in_data.coeff;
    // default result: a read that finds nothing, or an accumulate dropped when full
    if (in_data.op == OP_ACC) begin
      head.res.term_coeff = in_data.coeff;
      head.res.term_power = in_data.power;
      head.res.table_full = 1'b1;
    end
  end

  assign chain[0] = head;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    stac_cell #(
      .MAX_TERMS (MAX_TERMS),
      .POS       (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .count (count_r),
      .cin   (chain[k]),
      .cout  (chain[k + 1])
    );
  end

  assign tail     = chain[MAX_TERMS];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt      = count_r;
    busy_nxt       = busy_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (tail.vld) begin
      count_nxt           = count_r + CW'(tail.grew);
      pend_valid_nxt      = 1'b1;
      pend_nxt            = tail.res;
      pend_nxt.term_count = 5'(count_nxt);
    end
    if (pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = pend_r;
      pend_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      count_r      <= '0;
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      busy_r       <= busy_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_vld
    assign chain_vld[k] = chain[k + 1].vld;
  end
  assign chain_vld[MAX_TERMS] = pend_valid_r;

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count above table size");

  a_one_word : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one word in flight");

  a_idle_chain : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> chain_vld == '0)
    else $error("chain active while idle");

  a_flag_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.table_full && out_r.entry_valid)
                    && !(out_r.sum_saturated && !out_r.entry_valid))
    else $error("inconsistent result flags");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    !tail.vld |=> count_r == $past(count_r))
    else $error("term count changed without a finished word");

endmodule

// File: sim/sorted_term_accumulator_tb.sv
// testbench for the sorted term accumulator: directed table, random words, self-checking
`timescale 1ns / 1ps
module sorted_term_accumulator_tb;
  import stac_pkg::*;

  localparam int TABLE_DEPTH = MAX_TERMS_DEF;
  localparam int RANDOM_WORDS = 1324;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // predicted table contents, highest power first
  logic signed [15:0] held_power [TABLE_DEPTH];
  logic signed [31:0] held_coeff [TABLE_DEPTH];
  int held_count = 0;

  out_item_t expected_terms[$];
  stim_row_t stim_table[$];

  int errors = 0;
  int results_seen = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int n_inserted = 0;
  int n_hits = 0;
  int n_clamped = 0;
  int n_dropped = 0;
  int n_reads = 0;
  int n_read_miss = 0;

  sorted_term_accumulator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t mk_word(logic op, logic [31:0] c, logic [15:0] p,
                                       logic [3:0] idx);
    in_item_t w;
    w.op = op;
    w.coeff = c;
    w.power = p;
    w.index = idx;
    return w;
  endfunction

  function automatic out_item_t mk_term(logic [31:0] c, logic [15:0] p, logic [4:0] n,
                                        logic v, logic full, logic sat);
    out_item_t r;
    r.term_coeff = c;
    r.term_power = p;
    r.term_count = n;
    r.entry_valid = v;
    r.table_full = full;
    r.sum_saturated = sat;
    return r;
  endfunction

  // advances the predicted table by one word and returns its result
  function automatic out_item_t predict_term(in_item_t w);
    out_item_t r;
    logic [32:0] s;
    int slot;
    int pos;
    r = '0;
    if (w.op == OP_READ) begin
      n_reads++;
      if (int'(w.index) < held_count) begin
        r.term_coeff = held_coeff[w.index];
        r.term_power = held_power[w.index];
        r.entry_valid = 1'b1;
      end else begin
        n_read_miss++;
      end
      r.term_count = held_count[4:0];
      return r;
    end
    slot = -1;
    for (int i = 0; i < held_count; i++) begin
      if (held_power[i] == w.power && slot < 0) slot = i;
    end
    if (slot >= 0) begin
      n_hits++;
      s = {held_coeff[slot][31], held_coeff[slot]} + {w.coeff[31], w.coeff};
      // sign of the wide sum disagrees with bit 31: out of range
      if (s[32] != s[31]) begin
        r.sum_saturated = 1'b1;
        n_clamped++;
        held_coeff[slot] = s[32] ? COEFF_MIN : COEFF_MAX;
      end else begin
        held_coeff[slot] = s[31:0];
      end
      r.term_coeff = held_coeff[slot];
      r.term_power = w.power;
      r.entry_valid = 1'b1;
    end else if (held_count >= TABLE_DEPTH) begin
      n_dropped++;
      r.term_coeff = w.coeff;
      r.term_power = w.power;
      r.table_full = 1'b1;
    end else begin
      n_inserted++;
      pos = 0;
      while (pos < held_count && $signed(held_power[pos]) > $signed(w.power)) pos++;
      for (int i = held_count; i > pos; i--) begin
        held_power[i] = held_power[i - 1];
        held_coeff[i] = held_coeff[i - 1];
      end
      held_power[pos] = w.power;
      held_coeff[pos] = w.coeff;
      held_count++;
      r.term_coeff = w.coeff;
      r.term_power = w.power;
      r.entry_valid = 1'b1;
    end
    r.term_count = held_count[4:0];
    return r;
  endfunction

  // mostly hits on held powers, some new powers, some reads
  function automatic in_item_t random_word();
    in_item_t w;
    int k;
    w = mk_word(OP_ACC, $urandom, 16'($urandom), 4'($urandom));
    if ($urandom_range(99) < 20) begin
      w.op = OP_READ;
      return w;
    end
    if (held_count == 0) return w;
    k = $urandom_range(held_count - 1);
    if ($urandom_range(99) < 85) w.power = held_power[k];
    case ($urandom_range(7))
      3: w.coeff = $urandom_range(200) - 100;
      4: w.coeff = COEFF_MAX;
      5: w.coeff = COEFF_MIN;
      6: w.coeff = -held_coeff[k];
      7: w.coeff = $urandom_range(65535);
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(in_item_t w, bit typed, out_item_t want);
    stim_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    stim_table = {stim_table, row};
  endtask

  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    int gap;
    out_item_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_term(w);
    if (typed) predicted = want;
    expected_terms = {expected_terms, predicted};
    words_sent++;
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %h want %h", results_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected word, coeff", out_data.term_coeff, '0);
      end else begin
        want = expected_terms.pop_front();
        if (out_data.term_coeff !== want.term_coeff)
          report_mismatch("term_coeff", out_data.term_coeff, want.term_coeff);
        if (out_data.term_power !== want.term_power)
          report_mismatch("term_power", 32'(out_data.term_power), 32'(want.term_power));
        if (out_data.term_count !== want.term_count)
          report_mismatch("term_count", 32'(out_data.term_count), 32'(want.term_count));
        if (out_data.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", 32'(out_data.entry_valid), 32'(want.entry_valid));
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", 32'(out_data.table_full), 32'(want.table_full));
        if (out_data.sum_saturated !== want.sum_saturated)
          report_mismatch("sum_saturated", 32'(out_data.sum_saturated),
                          32'(want.sum_saturated));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results pending",
               idle_cycles, expected_terms.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: rotating stall patterns plus one long hold-off
  initial begin : receiver
    int cyc;
    bit held_off;
    cyc = 0;
    held_off = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (!held_off && results_seen >= 200) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case ((cyc / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(1) == 0);
        2: out_stall <= (cyc % 3 == 0);
        default: out_stall <= ($urandom_range(9) < 8);
      endcase
    end
  end

  initial begin : stimulus
    logic signed [15:0] fill_powers [13];
    fill_powers = '{16'sd100, -16'sd100, 16'sd1, -16'sd1, 16'sd32766, -16'sd32767,
                    16'sd7, -16'sd7, 16'sd500, -16'sd500, 16'sd2, 16'sd3, 16'sd4};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;

    // empty table, extremes, clamping both ways, zero coefficient, read past the end
    add_row(mk_word(OP_READ, '0, '0, 4'd0), 1'b1,
            mk_term('0, '0, 5'd0, 1'b0, 1'b0, 1'b0));
    add_row(mk_word(OP_READ, '0, '0, 4'd15), 1'b1,
            mk_term('0, '0, 5'd0, 1'b0, 1'b0, 1'b0));
    add_row(mk_word(OP_ACC, COEFF_MAX, 16'sh7FFF, 4'd0), 1'b1,
            mk_term(COEFF_MAX, 16'sh7FFF, 5'd1, 1'b1, 1'b0, 1'b0));
    add_row(mk_word(OP_ACC, COEFF_MIN, 16'sh8000, 4'd0), 1'b1,
            mk_term(COEFF_MIN, 16'sh8000, 5'd2, 1'b1, 1'b0, 1'b0));
    add_row(mk_word(OP_ACC, 32'sd1, 16'sh7FFF, 4'd0), 1'b1,
            mk_term(COEFF_MAX, 16'sh7FFF, 5'd2, 1'b1, 1'b0, 1'b1));
    add_row(mk_word(OP_ACC, -32'sd1, 16'sh8000, 4'd0), 1'b1,
            mk_term(COEFF_MIN, 16'sh8000, 5'd2, 1'b1, 1'b0, 1'b1));
    add_row(mk_word(OP_ACC, COEFF_MIN, 16'sh7FFF, 4'd0), 1'b0, '0);
    add_row(mk_word(OP_ACC, 32'sd1, 16'sh7FFF, 4'd0), 1'b0, '0);
    add_row(mk_word(OP_READ, '0, '0, 4'd0), 1'b0, '0);
    add_row(mk_word(OP_READ, '0, '0, 4'd2), 1'b1,
            mk_term('0, '0, 5'd2, 1'b0, 1'b0, 1'b0));
    add_row(mk_word(OP_ACC, COEFF_MAX, 16'sh8000, 4'd0), 1'b0, '0);
    add_row(mk_word(OP_ACC, 32'sd5, 16'sd0, 4'd0), 1'b0, '0);
    // fill the rest of the table in scrambled order of power
    foreach (fill_powers[i])
      add_row(mk_word(OP_ACC, $urandom, fill_powers[i], 4'd0), 1'b0, '0);
    add_row(mk_word(OP_ACC, 32'hDEAD_BEEF, 16'sd9, 4'd0), 1'b1,
            mk_term(32'hDEAD_BEEF, 16'sd9, 5'd16, 1'b0, 1'b1, 1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].typed,
                                      stim_table[i].want);
    for (int k = 0; k < RANDOM_WORDS; k++) send_word(random_word(), 1'b0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (2 * (TABLE_DEPTH + 2)) @(posedge clk);

    $display("run: %0d words, %0d new terms, %0d accumulations (%0d clamped), %0d dropped",
             words_sent, n_inserted, n_hits, n_clamped, n_dropped);
    $display("run: %0d reads (%0d past the held terms), %0d results, %0d mismatches",
             n_reads, n_read_miss, results_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sorted_term_accumulator.f
src/stac_pkg.sv
src/stac_cell.sv
src/sorted_term_accumulator.sv
sim/sorted_term_accumulator_tb.sv
